>>> sv/dla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_pkg: shared types and constants of the downlink layer action diff unit
// Table geometry, entry layout, action and register codes, index map.
// ----------------------------------------------------------------------------
package dla_pkg;

  localparam int CONSUMERS = 64;
  localparam int CONS_W    = 6;
  localparam int CONS_VALS = 1 << CONS_W;
  // only CONS_VALS distinct ids exist, so deeper tables never see the rest
  localparam int TBL_DEPTH = (CONSUMERS < CONS_VALS) ? CONSUMERS : CONS_VALS;
  localparam int IDX_W     = $clog2(TBL_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 16;

  typedef enum logic [1:0] {
    ACT_PAUSE  = 2'd0,
    ACT_RESUME = 2'd1,
    ACT_LAYERS = 2'd2,
    ACT_PRIO   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGRADE   = 3'd0,
    REG_SMALL_W   = 3'd1,
    REG_PRIO_HID  = 3'd2,
    REG_PRIO_SHR  = 3'd3,
    REG_PRIO_PIN  = 3'd4,
    REG_PRIO_SPK  = 3'd5,
    REG_PRIO_GRID = 3'd6
  } cfg_reg_t;

  localparam logic [1:0]  RST_DEGRADE   = 2'd0;
  localparam logic [15:0] RST_SMALL_W   = 16'd320;
  localparam logic [7:0]  RST_PRIO_HID  = 8'd0;
  localparam logic [7:0]  RST_PRIO_SHR  = 8'd255;
  localparam logic [7:0]  RST_PRIO_PIN  = 8'd200;
  localparam logic [7:0]  RST_PRIO_SPK  = 8'd150;
  localparam logic [7:0]  RST_PRIO_GRID = 8'd100;

  localparam logic [1:0] DEGRADE_CAP_SP  = 2'd1;
  localparam logic [1:0] DEGRADE_CAP_ALL = 2'd2;
  localparam logic [1:0] DEGRADE_BASE    = 2'd3;
  localparam logic [1:0] LAYER_TOP    = 2'd2;
  localparam logic [1:0] LAYER_MID    = 2'd1;
  localparam logic [1:0] LAYER_BASE   = 2'd0;

  typedef struct packed {
    logic [1:0]  degrade_level;
    logic [15:0] small_tile_width;
    logic [7:0]  prio_hidden;
    logic [7:0]  prio_screen_share;
    logic [7:0]  prio_pinned;
    logic [7:0]  prio_speaker;
    logic [7:0]  prio_grid;
  } cfg_t;

  typedef struct packed {
    logic [CONS_W-1:0] consumer;
    logic              visible;
    logic              is_video;
    logic              pinned;
    logic              screen_share;
    logic              active_speaker;
    logic [15:0]       tile_width;
    logic              was_paused;
  } sub_t;

  // classified subscription, held for the table update
  typedef struct packed {
    logic [CONS_W-1:0] consumer;
    logic              visible;
    logic              is_video;
    logic              was_paused;
    logic [7:0]        prio;
    logic [1:0]        spatial;
    logic [1:0]        temporal;
  } item_t;

  typedef struct packed {
    logic       paused;
    logic       layers_known;
    logic [1:0] spatial;
    logic [1:0] temporal;
    logic       prio_known;
    logic [7:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    action_t           action;
    logic [CONS_W-1:0] consumer;
    logic [1:0]        spatial;
    logic [1:0]        temporal;
    logic              key_frame;
    logic [7:0]        prio;
    logic              last;
  } res_t;

  // consumer id -> table row, worked out at elaboration
  function automatic logic [CONS_VALS*IDX_W-1:0] build_idx_map();
    logic [CONS_VALS*IDX_W-1:0] m;
    m = '0;
    for (int i = 0; i < CONS_VALS; i++) begin
      m[i*IDX_W +: IDX_W] = IDX_W'(i % TBL_DEPTH);
    end
    return m;
  endfunction

  localparam logic [CONS_VALS*IDX_W-1:0] IDX_MAP = build_idx_map();

endpackage

>>> sv/downlink_layer_action_diff_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downlink_layer_action_diff_unit: per-consumer layer/priority action diff
// Turns one subscription update into the pause, resume, set-layers and
// set-priority actions that change the consumer table.
// ----------------------------------------------------------------------------
// Usage:
//   A subscription transfers on a clock edge with start high and busy low.
//   The next cycle reads the consumer's table row from RAM; the cycle after
//   that shows the first action. Actions follow one per cycle on out_*,
//   each for exactly one cycle with out_strobe high; out_last marks the
//   final one. An update that changes nothing gives no action.
//   A subscription gives up to three actions. busy stays high through its
//   table read and while its earlier actions are shown, as the table has a
//   single read port and the output gives one action per cycle.
//   busy drops while the last action is still shown, so the next
//   subscription overlaps it.
//   The receiver takes every action; there is no stall.
//   Reset clears the table to not paused, layers and priority unknown, in
//   the same cycle (per-row valid flags), and restores register defaults.
//   Configuration writes (cfg_we) take effect at once; write only when idle.
// ----------------------------------------------------------------------------
module downlink_layer_action_diff_unit
  import dla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [CONS_W-1:0]    in_consumer,
  input  logic                 in_visible,
  input  logic                 in_is_video,
  input  logic                 in_pinned,
  input  logic                 in_screen_share,
  input  logic                 in_active_speaker,
  input  logic [15:0]          in_tile_width,
  input  logic                 in_was_paused,
  output logic                 out_strobe,
  output logic [1:0]           out_action,
  output logic [CONS_W-1:0]    out_consumer,
  output logic [1:0]           out_spatial_layer,
  output logic [1:0]           out_temporal_layer,
  output logic                 out_key_frame,
  output logic [7:0]           out_priority_res,
  output logic                 out_last
);

  cfg_t  cfg_r;
  sub_t  sub;
  item_t item;
  res_t  res;
  logic  load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.degrade_level     <= RST_DEGRADE;
      cfg_r.small_tile_width  <= RST_SMALL_W;
      cfg_r.prio_hidden       <= RST_PRIO_HID;
      cfg_r.prio_screen_share <= RST_PRIO_SHR;
      cfg_r.prio_pinned       <= RST_PRIO_PIN;
      cfg_r.prio_speaker      <= RST_PRIO_SPK;
      cfg_r.prio_grid         <= RST_PRIO_GRID;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEGRADE:   cfg_r.degrade_level     <= cfg_wdata[1:0];
        REG_SMALL_W:   cfg_r.small_tile_width  <= cfg_wdata;
        REG_PRIO_HID:  cfg_r.prio_hidden       <= cfg_wdata[7:0];
        REG_PRIO_SHR:  cfg_r.prio_screen_share <= cfg_wdata[7:0];
        REG_PRIO_PIN:  cfg_r.prio_pinned       <= cfg_wdata[7:0];
        REG_PRIO_SPK:  cfg_r.prio_speaker      <= cfg_wdata[7:0];
        REG_PRIO_GRID: cfg_r.prio_grid         <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign load = start && !busy;

  always_comb begin
    sub.consumer       = in_consumer;
    sub.visible        = in_visible;
    sub.is_video       = in_is_video;
    sub.pinned         = in_pinned;
    sub.screen_share   = in_screen_share;
    sub.active_speaker = in_active_speaker;
    sub.tile_width     = in_tile_width;
    sub.was_paused     = in_was_paused;
  end

  dla_class u_class (
    .clk   (clk),
    .load  (load),
    .sub   (sub),
    .cfg   (cfg_r),
    .item_r(item)
  );

  dla_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .consumer    (in_consumer),
    .item        (item),
    .busy        (busy),
    .res_strobe_r(out_strobe),
    .res_r       (res)
  );

  assign out_action         = res.action;
  assign out_consumer       = res.consumer;
  assign out_spatial_layer  = res.spatial;
  assign out_temporal_layer = res.temporal;
  assign out_key_frame      = res.key_frame;
  assign out_priority_res   = res.prio;
  assign out_last           = res.last;

endmodule

>>> sv/dla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/dla_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_class: subscription classifier
// Derives priority and capped spatial/temporal layers, registered at transfer.
// ----------------------------------------------------------------------------
module dla_class
  import dla_pkg::*;
(
  input  logic  clk,
  input  logic  load,
  input  sub_t  sub,
  input  cfg_t  cfg,
  output item_t item_r
);

  item_t      item_nxt;
  logic [7:0] prio;
  logic       big_tile;
  logic [1:0] sp;
  logic [1:0] tp;

  always_comb begin
    if (!sub.visible) begin
      prio = cfg.prio_hidden;
    end else if (sub.screen_share) begin
      prio = cfg.prio_screen_share;
    end else if (sub.pinned) begin
      prio = cfg.prio_pinned;
    end else if (sub.active_speaker) begin
      prio = cfg.prio_speaker;
    end else begin
      prio = cfg.prio_grid;
    end

    big_tile = sub.pinned || sub.screen_share || (sub.tile_width > cfg.small_tile_width);
    sp       = big_tile ? LAYER_TOP : LAYER_BASE;
    tp       = big_tile ? LAYER_TOP : LAYER_BASE;
    // degrade cap: 1 limits spatial, 2 limits both, 3 forces base
    if (cfg.degrade_level == DEGRADE_BASE) begin
      sp = LAYER_BASE;
      tp = LAYER_BASE;
    end else if (cfg.degrade_level == DEGRADE_CAP_ALL) begin
      if (sp > LAYER_MID) sp = LAYER_MID;
      if (tp > LAYER_MID) tp = LAYER_MID;
    end else if (cfg.degrade_level == DEGRADE_CAP_SP) begin
      if (sp > LAYER_MID) sp = LAYER_MID;
    end

    item_nxt.consumer   = sub.consumer;
    item_nxt.visible    = sub.visible;
    item_nxt.is_video   = sub.is_video;
    item_nxt.was_paused = sub.was_paused;
    item_nxt.prio       = prio;
    item_nxt.spatial    = sp;
    item_nxt.temporal   = tp;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> sv/dla_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_seq: consumer table read-modify-write and action sequencer
// Reads the entry, picks the non-redundant actions, writes back, emits them.
// ----------------------------------------------------------------------------
module dla_seq
  import dla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CONS_W-1:0] consumer,
  input  item_t             item,
  output logic              busy,
  output logic              res_strobe_r,
  output res_t              res_r
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [TBL_DEPTH-1:0] valid_r;
  logic [ENTRY_W-1:0] rdata;
  entry_t             cur;
  entry_t             upd;
  logic               accept;
  logic               tbl_we;
  logic [IDX_W-1:0]   raddr;

  logic               en_a, en_l, en_p, lyr_eq;
  action_t            act_a;
  action_t            q [3];
  logic [1:0]         n;
  action_t            q_r [3];
  logic [1:0]         rem_r;
  logic               kf_r;

  function automatic res_t make_res(action_t act, item_t it, logic kf, logic lst);
    res_t r;
    r.action    = act;
    r.consumer  = it.consumer;
    r.spatial   = (act == ACT_LAYERS) ? it.spatial : LAYER_BASE;
    r.temporal  = (act == ACT_LAYERS) ? it.temporal : LAYER_BASE;
    r.key_frame = (act == ACT_LAYERS) ? kf : 1'b0;
    r.prio      = it.prio;
    r.last      = lst;
    return r;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);
  assign raddr  = IDX_MAP[int'(consumer)*IDX_W +: IDX_W];
  assign tbl_we = (state_r == S_READ);

  dla_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(idx_r),
    .wdata(upd),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    // rows never written since reset read as cleared
    cur    = valid_r[idx_r] ? entry_t'(rdata) : '0;
    lyr_eq = cur.layers_known && (cur.spatial == item.spatial) &&
             (cur.temporal == item.temporal);
    // pause/resume follow was_paused alone; the stored paused bit is never consulted
    en_a   = item.visible ? item.was_paused : !item.was_paused;
    act_a  = item.visible ? ACT_RESUME : ACT_PAUSE;
    en_l   = item.visible && item.is_video && (item.was_paused || !lyr_eq);
    en_p   = !(cur.prio_known && (cur.prio == item.prio));

    q[0] = ACT_PRIO;
    q[1] = ACT_PRIO;
    q[2] = ACT_PRIO;
    n    = 2'd0;
    if (en_a) begin
      q[n] = act_a;
      n    = n + 2'd1;
    end
    if (en_l) begin
      q[n] = ACT_LAYERS;
      n    = n + 2'd1;
    end
    if (en_p) begin
      q[n] = ACT_PRIO;
      n    = n + 2'd1;
    end

    upd.paused       = !item.visible;
    upd.layers_known = cur.layers_known || (item.visible && item.is_video);
    upd.spatial      = (item.visible && item.is_video) ? item.spatial : cur.spatial;
    upd.temporal     = (item.visible && item.is_video) ? item.temporal : cur.temporal;
    upd.prio_known   = 1'b1;
    upd.prio         = item.prio;

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_READ;
      S_READ: state_nxt = (n > 2'd1) ? S_EMIT : S_IDLE;
      S_EMIT: if (rem_r == 2'd1) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_strobe_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      res_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) idx_r <= raddr;
        end
        S_READ: begin
          valid_r[idx_r] <= 1'b1;
          kf_r           <= item.was_paused;
          if (n != 2'd0) begin
            res_strobe_r <= 1'b1;
            res_r        <= make_res(q[0], item, item.was_paused, n == 2'd1);
          end
          q_r[0] <= q[1];
          q_r[1] <= q[2];
          q_r[2] <= ACT_PRIO;
          rem_r  <= n - 2'd1;
        end
        S_EMIT: begin
          res_strobe_r <= 1'b1;
          res_r        <= make_res(q_r[0], item, kf_r, rem_r == 2'd1);
          q_r[0]       <= q_r[1];
          q_r[1]       <= q_r[2];
          rem_r        <= rem_r - 2'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for downlink_layer_action_diff_unit
// Drives subscription updates through the start/busy port and mirrors the
// consumer table in a behavioral diff predictor. Each strobed action is
// checked in order against the predicted ones. A short table of directed
// updates comes first. Random phases follow, each with its own register
// setting, and the bench drains between them.
// ----------------------------------------------------------------------------
module tb_top;
  import dla_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 58;
  localparam int DIR_ROWS      = 17;
  localparam int REPORT_MAX    = 10;

  // degrade levels below full base-layer forcing
  localparam logic [1:0] DEG_CAP_SPATIAL = 2'd1;
  localparam logic [1:0] DEG_CAP_BOTH    = 2'd2;

  typedef struct packed {
    sub_t sub;
    logic typed;    // expectation given in the row, not by the predictor
    logic has_res;  // typed row: one action expected, else none
    res_t res;
  } stim_row_t;

  localparam res_t NO_RES = '0;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_wdata;
  logic                 start;
  logic                 busy;
  logic [CONS_W-1:0]    in_consumer;
  logic                 in_visible;
  logic                 in_is_video;
  logic                 in_pinned;
  logic                 in_screen_share;
  logic                 in_active_speaker;
  logic [15:0]          in_tile_width;
  logic                 in_was_paused;
  logic                 out_strobe;
  logic [1:0]           out_action;
  logic [CONS_W-1:0]    out_consumer;
  logic [1:0]           out_spatial_layer;
  logic [1:0]           out_temporal_layer;
  logic                 out_key_frame;
  logic [7:0]           out_priority_res;
  logic                 out_last;

  entry_t    cons_shadow [CONSUMERS];
  cfg_t      cfg_shadow;
  res_t      pending_actions [$];
  stim_row_t dir_rows [DIR_ROWS];
  res_t      got_act;
  res_t      want_act;
  int        mismatches;
  int        cycle_cnt;
  bit        no_idle;

  downlink_layer_action_diff_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_consumer        (in_consumer),
    .in_visible         (in_visible),
    .in_is_video        (in_is_video),
    .in_pinned          (in_pinned),
    .in_screen_share    (in_screen_share),
    .in_active_speaker  (in_active_speaker),
    .in_tile_width      (in_tile_width),
    .in_was_paused      (in_was_paused),
    .out_strobe         (out_strobe),
    .out_action         (out_action),
    .out_consumer       (out_consumer),
    .out_spatial_layer  (out_spatial_layer),
    .out_temporal_layer (out_temporal_layer),
    .out_key_frame      (out_key_frame),
    .out_priority_res   (out_priority_res),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sub_t mk_sub(logic [CONS_W-1:0] c, logic vis, logic vid, logic pin,
                                  logic shr, logic spk, logic [15:0] w, logic wp);
    sub_t s;
    s.consumer       = c;
    s.visible        = vis;
    s.is_video       = vid;
    s.pinned         = pin;
    s.screen_share   = shr;
    s.active_speaker = spk;
    s.tile_width     = w;
    s.was_paused     = wp;
    return s;
  endfunction

  function automatic res_t mk_res(action_t a, logic [CONS_W-1:0] c, logic [1:0] sp,
                                  logic [1:0] tp, logic kf, logic [7:0] p, logic l);
    res_t r;
    r.action    = a;
    r.consumer  = c;
    r.spatial   = sp;
    r.temporal  = tp;
    r.key_frame = kf;
    r.prio      = p;
    r.last      = l;
    return r;
  endfunction

  function automatic string act_str(res_t r);
    return $sformatf("act=%0d cons=%0d sp=%0d tp=%0d kf=%0d prio=%0d last=%0d",
                     r.action, r.consumer, r.spatial, r.temporal, r.key_frame,
                     r.prio, r.last);
  endfunction

  // Diff one subscription against the shadow table; queue the actions it causes.
  function automatic void diff_subscription(sub_t s);
    entry_t     e;
    res_t       acts [3];
    int         n;
    logic [7:0] pr;
    logic [1:0] sp;
    logic [1:0] tp;
    logic       large_tile;
    n = 0;
    e = cons_shadow[s.consumer];
    e.paused = s.was_paused;

    if (!s.visible) pr = cfg_shadow.prio_hidden;
    else if (s.screen_share) pr = cfg_shadow.prio_screen_share;
    else if (s.pinned) pr = cfg_shadow.prio_pinned;
    else if (s.active_speaker) pr = cfg_shadow.prio_speaker;
    else pr = cfg_shadow.prio_grid;

    large_tile = s.pinned | s.screen_share | (s.tile_width > cfg_shadow.small_tile_width);
    sp = large_tile ? LAYER_TOP : LAYER_BASE;
    tp = sp;
    case (cfg_shadow.degrade_level)
      DEGRADE_BASE: begin
        sp = LAYER_BASE;
        tp = LAYER_BASE;
      end
      DEG_CAP_BOTH: begin
        if (sp > LAYER_MID) sp = LAYER_MID;
        if (tp > LAYER_MID) tp = LAYER_MID;
      end
      DEG_CAP_SPATIAL: begin
        if (sp > LAYER_MID) sp = LAYER_MID;
      end
      default: ;
    endcase

    // paused was just loaded from was_paused, so pause/resume are never redundant
    if (!s.visible) begin
      if (!s.was_paused) begin
        e.paused = 1'b1;
        acts[n] = mk_res(ACT_PAUSE, s.consumer, LAYER_BASE, LAYER_BASE, 1'b0, pr, 1'b0);
        n++;
      end
    end else if (!s.is_video) begin
      if (s.was_paused) begin
        e.paused = 1'b0;
        acts[n] = mk_res(ACT_RESUME, s.consumer, LAYER_BASE, LAYER_BASE, 1'b0, pr, 1'b0);
        n++;
      end
    end else if (s.was_paused) begin
      e.paused       = 1'b0;
      e.layers_known = 1'b1;
      e.spatial      = sp;
      e.temporal     = tp;
      acts[n] = mk_res(ACT_RESUME, s.consumer, LAYER_BASE, LAYER_BASE, 1'b0, pr, 1'b0);
      n++;
      // key-frame layer switch always goes out
      acts[n] = mk_res(ACT_LAYERS, s.consumer, sp, tp, 1'b1, pr, 1'b0);
      n++;
    end else if (!(e.layers_known && e.spatial == sp && e.temporal == tp)) begin
      e.layers_known = 1'b1;
      e.spatial      = sp;
      e.temporal     = tp;
      acts[n] = mk_res(ACT_LAYERS, s.consumer, sp, tp, 1'b0, pr, 1'b0);
      n++;
    end

    if (!(e.prio_known && e.prio == pr)) begin
      e.prio_known = 1'b1;
      e.prio       = pr;
      acts[n] = mk_res(ACT_PRIO, s.consumer, LAYER_BASE, LAYER_BASE, 1'b0, pr, 1'b0);
      n++;
    end

    cons_shadow[s.consumer] = e;
    if (n > 0) acts[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_actions.insert(pending_actions.size(), acts[i]);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 11) == 0) no_idle = ~no_idle;
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Present one update and hold it until the transfer.
  task automatic send_sub(stim_row_t row, int gap);
    int depth;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_consumer       <= row.sub.consumer;
    in_visible        <= row.sub.visible;
    in_is_video       <= row.sub.is_video;
    in_pinned         <= row.sub.pinned;
    in_screen_share   <= row.sub.screen_share;
    in_active_speaker <= row.sub.active_speaker;
    in_tile_width     <= row.sub.tile_width;
    in_was_paused     <= row.sub.was_paused;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    depth = pending_actions.size();
    diff_subscription(row.sub);
    if (row.typed) begin
      while (pending_actions.size() > depth) void'(pending_actions.pop_back());
      if (row.has_res) pending_actions.insert(pending_actions.size(), row.res);
    end
  endtask

  // Wait for every action to arrive, then let an empty update finish too.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    logic [CFG_DW-1:0] vals [REG_PRIO_GRID+1];
    // unused upper bits carry junk; the block must ignore them
    vals[REG_DEGRADE]   = {14'($urandom), c.degrade_level};
    vals[REG_SMALL_W]   = c.small_tile_width;
    vals[REG_PRIO_HID]  = {8'($urandom), c.prio_hidden};
    vals[REG_PRIO_SHR]  = {8'($urandom), c.prio_screen_share};
    vals[REG_PRIO_PIN]  = {8'($urandom), c.prio_pinned};
    vals[REG_PRIO_SPK]  = {8'($urandom), c.prio_speaker};
    vals[REG_PRIO_GRID] = {8'($urandom), c.prio_grid};
    for (int i = REG_DEGRADE; i <= REG_PRIO_GRID; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("downlink_layer_action_diff_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      got_act.action    = action_t'(out_action);
      got_act.consumer  = out_consumer;
      got_act.spatial   = out_spatial_layer;
      got_act.temporal  = out_temporal_layer;
      got_act.key_frame = out_key_frame;
      got_act.prio      = out_priority_res;
      got_act.last      = out_last;
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: action with none pending: %s", $time, act_str(got_act));
      end else begin
        want_act = pending_actions.pop_front();
        if (got_act !== want_act) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: wrong action\n  exp %s\n  got %s", $time,
                     act_str(want_act), act_str(got_act));
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    cfg_t      c;
    logic [15:0] sw;

    mismatches = 0;
    cycle_cnt  = 0;
    no_idle    = 1'b0;
    for (int i = 0; i < CONSUMERS; i++) cons_shadow[i] = '0;
    cfg_shadow.degrade_level     = RST_DEGRADE;
    cfg_shadow.small_tile_width  = RST_SMALL_W;
    cfg_shadow.prio_hidden       = RST_PRIO_HID;
    cfg_shadow.prio_screen_share = RST_PRIO_SHR;
    cfg_shadow.prio_pinned       = RST_PRIO_PIN;
    cfg_shadow.prio_speaker      = RST_PRIO_SPK;
    cfg_shadow.prio_grid         = RST_PRIO_GRID;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    start             <= 1'b0;
    in_consumer       <= '0;
    in_visible        <= 1'b0;
    in_is_video       <= 1'b0;
    in_pinned         <= 1'b0;
    in_screen_share   <= 1'b0;
    in_active_speaker <= 1'b0;
    in_tile_width     <= '0;
    in_was_paused     <= 1'b0;

    // directed updates under reset defaults; fresh rows have nothing known
    dir_rows[0]  = '{mk_sub(6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1), 1'b1, 1'b1,
                     mk_res(ACT_PRIO, 6'd0, LAYER_BASE, LAYER_BASE, 1'b0, 8'd0, 1'b1)};
    dir_rows[1]  = '{mk_sub(6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1), 1'b1, 1'b0,
                     NO_RES};
    dir_rows[2]  = '{mk_sub(6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0), 1'b1, 1'b1,
                     mk_res(ACT_PAUSE, 6'd0, LAYER_BASE, LAYER_BASE, 1'b0, 8'd0, 1'b1)};
    dir_rows[3]  = '{mk_sub(6'd63, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF, 1'b0), 1'b1, 1'b1,
                     mk_res(ACT_PRIO, 6'd63, LAYER_BASE, LAYER_BASE, 1'b0, 8'd255, 1'b1)};
    dir_rows[4]  = '{mk_sub(6'd63, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF, 1'b1), 1'b1, 1'b1,
                     mk_res(ACT_RESUME, 6'd63, LAYER_BASE, LAYER_BASE, 1'b0, 8'd255, 1'b1)};
    dir_rows[5]  = '{mk_sub(6'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd320, 1'b0), 1'b0, 1'b0,
                     NO_RES};
    // one pixel over the small-tile threshold: top layers, priority unchanged
    dir_rows[6]  = '{mk_sub(6'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd321, 1'b0), 1'b1, 1'b1,
                     mk_res(ACT_LAYERS, 6'd1, LAYER_TOP, LAYER_TOP, 1'b0, 8'd100, 1'b1)};
    dir_rows[7]  = '{mk_sub(6'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b1), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[8]  = '{mk_sub(6'd2, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[9]  = '{mk_sub(6'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[10] = '{mk_sub(6'd4, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 16'h5555, 1'b1), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[11] = '{mk_sub(6'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'hAAAA, 1'b1), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[12] = '{mk_sub(6'd5, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b0), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[13] = '{mk_sub(6'd6, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[14] = '{mk_sub(6'd5, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, 1'b0), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[15] = '{mk_sub(6'd7, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1), 1'b0, 1'b0,
                     NO_RES};
    dir_rows[16] = '{mk_sub(6'd42, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0), 1'b0, 1'b0,
                     NO_RES};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_sub(dir_rows[i], pick_gap());

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0: sw = 16'd0;
        1: sw = 16'hFFFF;
        2: sw = RST_SMALL_W;
        default: sw = 16'($urandom);
      endcase
      c.degrade_level     = 2'($urandom);
      c.small_tile_width  = sw;
      c.prio_hidden       = 8'($urandom);
      c.prio_screen_share = 8'($urandom);
      c.prio_pinned       = 8'($urandom);
      c.prio_speaker      = 8'($urandom);
      c.prio_grid         = 8'($urandom);
      case (ph)
        0: c.degrade_level = DEG_CAP_SPATIAL;
        1: c.degrade_level = DEG_CAP_BOTH;
        2: begin
          c.degrade_level    = DEGRADE_BASE;
          c.small_tile_width = 16'd0;
          c.prio_hidden = 8'hFF; c.prio_screen_share = 8'hFF; c.prio_pinned = 8'hFF;
          c.prio_speaker = 8'hFF; c.prio_grid = 8'hFF;
        end
        3: begin
          c.degrade_level    = 2'd0;
          c.small_tile_width = 16'hFFFF;
          c.prio_hidden = 8'h00; c.prio_screen_share = 8'h00; c.prio_pinned = 8'h00;
          c.prio_speaker = 8'h00; c.prio_grid = 8'h00;
        end
        4: begin
          // few distinct priorities, so category changes often leave it alone
          c.prio_hidden       = 8'($urandom_range(0, 1));
          c.prio_screen_share = 8'($urandom_range(0, 1));
          c.prio_pinned       = 8'($urandom_range(0, 1));
          c.prio_speaker      = 8'($urandom_range(0, 1));
          c.prio_grid         = 8'($urandom_range(0, 1));
        end
        default: ;
      endcase
      load_config(c);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        row = '0;
        // mostly a small pool of consumers so table entries get revisited
        row.sub.consumer = ($urandom_range(0, 3) == 0) ? CONS_W'($urandom)
                                                       : CONS_W'($urandom_range(0, 7));
        row.sub.visible        = ($urandom_range(0, 3) != 0);
        row.sub.is_video       = ($urandom_range(0, 3) != 0);
        row.sub.pinned         = ($urandom_range(0, 4) == 0);
        row.sub.screen_share   = ($urandom_range(0, 5) == 0);
        row.sub.active_speaker = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
          0: row.sub.tile_width = 16'd0;
          1: row.sub.tile_width = 16'hFFFF;
          2: row.sub.tile_width = cfg_shadow.small_tile_width;
          3: row.sub.tile_width = cfg_shadow.small_tile_width + 16'd1;
          default: row.sub.tile_width = 16'($urandom);
        endcase
        // usually report the pause state the consumer really has
        row.sub.was_paused = ($urandom_range(0, 3) == 0) ? 1'($urandom)
                                                        : cons_shadow[row.sub.consumer].paused;
        send_sub(row, pick_gap());
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("downlink_layer_action_diff_unit: match");
    end else begin
      $display("downlink_layer_action_diff_unit: mismatch");
    end
    $finish;
  end

endmodule
